FILE: hdl/icrb_pkg.sv
`timescale 1ns / 1ps
package icrb_pkg;

   // pixel and coefficient formats
   localparam int PIX_W   = 8;
   localparam int COEF_W  = 12;
   localparam int FRAC_W  = 10;
   localparam int PROD_W  = COEF_W + PIX_W + 1;
   // row and width arithmetic, wide enough for the largest width and height plus radius
   localparam int WV_W    = 14;
   localparam int HGT_W   = 13;
   localparam int RAD_W   = 2;
   localparam int CNT_W   = 2;
   localparam int KROWS   = 5;
   localparam int ROW_REG_W = COEF_W * KROWS;
   localparam int MAX_HEIGHT = 4096;

   typedef logic [PIX_W-1:0]         pix_type;
   typedef logic signed [COEF_W-1:0] coef_type;

   typedef enum logic [2:0] {
      CSR_RADIUS = 3'd0,
      CSR_WIDTH  = 3'd1,
      CSR_HEIGHT = 3'd2,
      CSR_COEF0  = 3'd3,
      CSR_COEF1  = 3'd4,
      CSR_COEF2  = 3'd5,
      CSR_COEF3  = 3'd6,
      CSR_COEF4  = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic row_end;
      logic image_end;
      logic last;
   } res_flags_type;

endpackage

FILE: hdl/image_conv2d_replicate_border_core.sv
`timescale 1ns / 1ps
// channel   dir  handshake              payload
// req       in   req_tvalid/req_tready  tdata[7:0] pixel_in, tuser[0] req_type
// rsp       out  rsp_tvalid/rsp_tready  tdata[7:0] pixel_out, tuser row_end/image_end,
//                                       tlast last_of_run
// csr       in   csr_valid/csr_ready    csr_index[2:0], csr_data[59:0]
//
// one pixel beat per clock unless rsp_tready stalls; a row end gives up to radius+1
// results, one per clock, so the input stalls there (set by the single result datapath)
// registers: stage 1, window, tap, product, row sum, pixel; line store read is registered
// synchronous active-high reset clears counters, window and valid bits; line store is not
// cleared and needs no clearing pass
// rsp_tready low stalls the result pipeline and then the input through req_tready
module image_conv2d_replicate_border_core
   import icrb_pkg::*;
#(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_RADIUS = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] pixel_in
   input  logic        req_tuser,   // [0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] pixel_out
   output logic [1:0]  rsp_tuser,   // [0] row_end, [1] image_end
   output logic        rsp_tlast,   // last_of_run
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [59:0] csr_data
);

   localparam int SPAN   = 2 * MAX_RADIUS + 1;
   localparam int SLOTS  = 2 * MAX_RADIUS;
   localparam int SLOT_W = (SLOTS > 2) ? $clog2(SLOTS) : 1;
   localparam int CW     = $clog2(MAX_WIDTH);
   localparam int OCW    = CW + 1;
   localparam int POS_W  = $clog2(SPAN);

   // configuration registers
   logic [RAD_W-1:0]     radius_ff;
   logic [11:0]          width_ff;
   logic [HGT_W-1:0]     height_ff;
   logic [ROW_REG_W-1:0] coeff_ff [KROWS];

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RAD_W'(1);
         width_ff  <= 12'd640;
         height_ff <= HGT_W'(480);
         for (int i = 0; i < KROWS; i++) coeff_ff[i] <= '0;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_RADIUS: radius_ff   <= csr_data[RAD_W-1:0];
            CSR_WIDTH:  width_ff    <= csr_data[11:0];
            CSR_HEIGHT: height_ff   <= csr_data[HGT_W-1:0];
            CSR_COEF0:  coeff_ff[0] <= csr_data;
            CSR_COEF1:  coeff_ff[1] <= csr_data;
            CSR_COEF2:  coeff_ff[2] <= csr_data;
            CSR_COEF3:  coeff_ff[3] <= csr_data;
            CSR_COEF4:  coeff_ff[4] <= csr_data;
            default: ;
         endcase
      end
   end
   assign csr_ready = 1'b1;

   // effective geometry, out-of-range values folded into range
   logic [RAD_W-1:0] r_eff;
   logic [WV_W-1:0]  w_eff, wm1, h_eff, rv;

   always_comb begin
      if (radius_ff == '0) r_eff = RAD_W'(1);
      else if (radius_ff > RAD_W'(MAX_RADIUS)) r_eff = RAD_W'(MAX_RADIUS);
      else r_eff = radius_ff;
      if (width_ff == '0) w_eff = WV_W'(1);
      else if (WV_W'(width_ff) > WV_W'(MAX_WIDTH)) w_eff = WV_W'(MAX_WIDTH);
      else w_eff = WV_W'(width_ff);
      if (height_ff == '0) h_eff = WV_W'(1);
      else if (WV_W'(height_ff) > WV_W'(MAX_HEIGHT)) h_eff = WV_W'(MAX_HEIGHT);
      else h_eff = WV_W'(height_ff);
      wm1 = w_eff - WV_W'(1);
      rv  = WV_W'(r_eff);
   end

   // stream position
   logic [CW-1:0]    in_col_ff, in_col_in;
   logic [HGT_W-1:0] in_row_ff, in_row_in;
   logic [OCW-1:0]   out_col_ff, out_col_in;

   // input stage control
   logic             accept, drop, flush_row, last_col, final_row, out_en;
   logic [CW-1:0]    col_c;
   logic [WV_W-1:0]  row, end_col, diff;
   logic [CNT_W-1:0] n_res;
   logic             use_pix [SPAN];
   logic [SLOT_W-1:0] slot_sel [SPAN];

   always_comb begin
      logic signed [WV_W:0] q;
      row       = WV_W'(in_row_ff);
      flush_row = row >= h_eff;
      drop      = req_tuser != flush_row;
      last_col  = WV_W'(in_col_ff) >= wm1;
      col_c     = last_col ? wm1[CW-1:0] : in_col_ff;
      final_row = row >= (h_eff + rv - WV_W'(1));
      out_en    = (row >= rv) && (last_col || (WV_W'(col_c) >= rv));
      end_col   = last_col ? wm1 : (WV_W'(col_c) - rv);
      diff      = end_col - WV_W'(out_col_ff) + WV_W'(1);
      n_res     = '0;
      if (out_en && (WV_W'(out_col_ff) <= end_col)) begin
         n_res = (diff > rv + WV_W'(1)) ? CNT_W'(r_eff + RAD_W'(1)) : diff[CNT_W-1:0];
      end
      out_col_in = last_col ? '0 : out_col_ff + OCW'(n_res);
      in_col_in  = last_col ? '0 : in_col_ff + CW'(1);
      in_row_in  = last_col ? (final_row ? '0 : in_row_ff + HGT_W'(1)) : in_row_ff;
      // rows row-2r..row clamped to the image
      for (int k = 0; k < SPAN; k++) begin
         q = $signed({1'b0, row}) - $signed({1'b0, rv[WV_W-2:0], 1'b0}) + (WV_W+1)'(k);
         if (q < 0) q = '0;
         if (q > $signed({1'b0, h_eff - WV_W'(1)})) q = $signed({1'b0, h_eff - WV_W'(1)});
         use_pix[k]  = !flush_row && (q[WV_W-1:0] == row);
         slot_sel[k] = q[SLOT_W-1:0];
      end
   end

   // stage 1 and result stage registers
   logic              s1_valid_ff, s1_go;
   pix_type           s1_pix_ff;
   logic [CW-1:0]     s1_c_ff;
   logic              s1_final_ff;
   logic [CW-1:0]     s1_j0_ff;
   logic [CNT_W-1:0]  s1_n_ff;
   logic              s1_use_ff [SPAN];
   logic [SLOT_W-1:0] s1_slot_ff [SPAN];
   pix_type           rd_ff [SLOTS];
   pix_type           line_mem [SLOTS][MAX_WIDTH];

   logic              s2_valid_ff, s2_final_ff, s2_free, emit, en;
   logic [CW-1:0]     s2_j_ff, s2_c_ff;
   logic [CNT_W-1:0]  s2_cnt_ff;
   pix_type           window_ff [SPAN][SPAN];  // [position][kernel row], newest last
   pix_type           vec [SPAN];

   logic              mac_valid;
   pix_type           mac_pixel;
   res_flags_type     mac_flags, emit_flags;

   assign en         = !mac_valid || rsp_tready;
   assign emit       = s2_valid_ff && en;
   assign s2_free    = !s2_valid_ff || (emit && (s2_cnt_ff == CNT_W'(1)));
   assign s1_go      = s1_valid_ff && s2_free;
   assign req_tready = !s1_valid_ff || s1_go;
   assign accept     = req_tvalid && req_tready;

   // line store, one bank per buffered row, read before write at the same column
   for (genvar gb = 0; gb < SLOTS; gb++) begin : g_bank
      always_ff @(posedge clock) begin
         if (accept && !drop && !flush_row && (in_row_ff[SLOT_W-1:0] == SLOT_W'(gb))) begin
            line_mem[gb][col_c] <= req_tdata;
         end
         if (accept) begin
            rd_ff[gb] <= line_mem[gb][col_c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         out_col_ff  <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (accept && !drop) begin
            in_col_ff  <= in_col_in;
            in_row_ff  <= in_row_in;
            out_col_ff <= out_col_in;
         end
         if (accept) s1_valid_ff <= !drop;
         else if (s1_go) s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff   <= req_tdata;
         s1_c_ff     <= col_c;
         s1_final_ff <= final_row;
         s1_j0_ff    <= out_col_ff[CW-1:0];
         s1_n_ff     <= n_res;
         s1_use_ff   <= use_pix;
         s1_slot_ff  <= slot_sel;
      end
   end

   always_comb begin
      for (int k = 0; k < SPAN; k++) begin
         vec[k] = s1_use_ff[k] ? s1_pix_ff : rd_ff[s1_slot_ff[k]];
      end
   end

   // window and result sequencing
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s2_cnt_ff   <= '0;
         for (int p = 0; p < SPAN; p++)
            for (int k = 0; k < SPAN; k++) window_ff[p][k] <= '0;
      end else begin
         if (s1_go) begin
            // column zero replicates the left edge into every position
            for (int p = 0; p < SPAN; p++) begin
               if (s1_c_ff == '0 || p == SPAN - 1) window_ff[p] <= vec;
               else window_ff[p] <= window_ff[(p + 1) % SPAN];
            end
            s2_valid_ff <= s1_n_ff != '0;
            s2_cnt_ff   <= s1_n_ff;
         end else if (emit) begin
            s2_cnt_ff   <= s2_cnt_ff - CNT_W'(1);
            s2_valid_ff <= s2_cnt_ff != CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         s2_j_ff     <= s1_j0_ff;
         s2_c_ff     <= s1_c_ff;
         s2_final_ff <= s1_final_ff;
      end else if (emit) begin
         s2_j_ff <= s2_j_ff + CW'(1);
      end
   end

   // tap gather for output column j: replicate right edge, clamp into window
   pix_type  taps [SPAN][SPAN];
   coef_type coefs [SPAN][SPAN];

   always_comb begin
      logic signed [WV_W+1:0] colv, d;
      logic [POS_W-1:0]       pos;
      for (int l = 0; l < SPAN; l++) begin
         colv = $signed({2'b00, WV_W'(s2_j_ff)}) + (WV_W+2)'(l) - $signed({2'b00, rv});
         if (colv > $signed({2'b00, wm1})) colv = $signed({2'b00, wm1});
         d = $signed({2'b00, WV_W'(s2_c_ff)}) - colv;
         if (d < 0) d = '0;
         if (d > (WV_W+2)'(SPAN - 1)) d = (WV_W+2)'(SPAN - 1);
         pos = POS_W'(SPAN - 1) - d[POS_W-1:0];
         for (int k = 0; k < SPAN; k++) begin
            taps[k][l] = window_ff[pos][k];
            if ((k <= 2 * int'(r_eff)) && (l <= 2 * int'(r_eff)))
               coefs[k][l] = coeff_ff[k][COEF_W*l +: COEF_W];
            else
               coefs[k][l] = '0;
         end
      end
      emit_flags.row_end   = WV_W'(s2_j_ff) == wm1;
      emit_flags.image_end = (WV_W'(s2_j_ff) == wm1) && s2_final_ff;
      emit_flags.last      = s2_cnt_ff == CNT_W'(1);
   end

   icrb_mac #(
      .SPAN (SPAN)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s2_valid_ff),
      .in_taps   (taps),
      .coefs     (coefs),
      .in_flags  (emit_flags),
      .out_valid (mac_valid),
      .out_pixel (mac_pixel),
      .out_flags (mac_flags)
   );

   assign rsp_tvalid = mac_valid;
   assign rsp_tdata  = mac_pixel;
   assign rsp_tuser  = {mac_flags.image_end, mac_flags.row_end};
   assign rsp_tlast  = mac_flags.last;

   // an image end is always also a row end
   a_image_end_row: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[0])
      else $error("image end without row end");

   // a busy result sequencer never runs past the row
   a_j_in_row: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> (WV_W'(s2_j_ff) <= wm1))
      else $error("output column beyond row");

   // at most radius+1 results per input beat
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> (s2_cnt_ff != '0) && (s2_cnt_ff <= CNT_W'(r_eff + RAD_W'(1))))
      else $error("result count out of range");

   // a stalled result sequencer holds its column
   a_seq_hold: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !en |=> $stable(s2_j_ff))
      else $error("sequencer moved while stalled");

endmodule

FILE: hdl/icrb_mac.sv
`timescale 1ns / 1ps
module icrb_mac
   import icrb_pkg::*;
#(
   parameter int SPAN = 5
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  pix_type       in_taps [SPAN][SPAN],
   input  coef_type      coefs [SPAN][SPAN],
   input  res_flags_type in_flags,
   output logic          out_valid,
   output pix_type       out_pixel,
   output res_flags_type out_flags
);

   localparam int ROW_W = PROD_W + $clog2(SPAN);
   localparam int ACC_W = ROW_W + $clog2(SPAN);
   localparam int Q_W   = ACC_W - FRAC_W;
   localparam logic [FRAC_W-1:0] HALF = FRAC_W'(1) << (FRAC_W - 1);

   logic                     a_valid_ff, b_valid_ff, c_valid_ff, out_valid_ff;
   res_flags_type            a_flags_ff, b_flags_ff, c_flags_ff, out_flags_ff;
   pix_type                  tap_ff [SPAN][SPAN];
   logic signed [PROD_W-1:0] prod_ff [SPAN][SPAN];
   logic signed [PROD_W-1:0] prod_in [SPAN][SPAN];
   logic signed [ROW_W-1:0]  rsum_ff [SPAN];
   logic signed [ROW_W-1:0]  rsum_in [SPAN];
   pix_type                  pix_ff, pix_in;

   // products
   always_comb begin
      for (int k = 0; k < SPAN; k++) begin
         for (int l = 0; l < SPAN; l++) begin
            prod_in[k][l] = PROD_W'(coefs[k][l] * $signed({1'b0, tap_ff[k][l]}));
         end
      end
   end

   // row sums
   always_comb begin
      logic signed [ROW_W-1:0] acc;
      for (int k = 0; k < SPAN; k++) begin
         acc = '0;
         for (int l = 0; l < SPAN; l++) begin
            acc = acc + ROW_W'(prod_ff[k][l]);
         end
         rsum_in[k] = acc;
      end
   end

   // total, round half to even, clamp
   always_comb begin
      logic signed [ACC_W-1:0] total;
      logic [Q_W-1:0]          q;
      logic [FRAC_W-1:0]       rem;
      logic [Q_W:0]            qr;
      logic                    up;
      total = '0;
      for (int k = 0; k < SPAN; k++) begin
         total = total + ACC_W'(rsum_ff[k]);
      end
      q   = total[ACC_W-1:FRAC_W];
      rem = total[FRAC_W-1:0];
      up  = (rem > HALF) || ((rem == HALF) && q[0]);
      qr  = {1'b0, q} + (Q_W+1)'(up);
      if (total <= 0) begin
         pix_in = '0;
      end else if (qr > (Q_W+1)'(255)) begin
         pix_in = 8'hff;
      end else begin
         pix_in = qr[PIX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff   <= in_valid;
         b_valid_ff   <= a_valid_ff;
         c_valid_ff   <= b_valid_ff;
         out_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff       <= in_taps;
         a_flags_ff   <= in_flags;
         prod_ff      <= prod_in;
         b_flags_ff   <= a_flags_ff;
         rsum_ff      <= rsum_in;
         c_flags_ff   <= b_flags_ff;
         pix_ff       <= pix_in;
         out_flags_ff <= c_flags_ff;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_pixel = pix_ff;
   assign out_flags = out_flags_ff;

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import icrb_pkg::*;

   // one expected output pixel with its marks
   typedef struct {
      logic [7:0] pixel;
      logic       row_end;
      logic       image_end;
      logic       last;
   } conv_result_type;

   // mirror of the convolution engine: registers, line store, window and counters
   class conv_scoreboard;
      int unsigned     radius_reg, width_reg, height_reg;
      logic [59:0]     coef_row [5];
      logic [7:0]      line_store [4*2048];
      logic [7:0]      window [25];
      int              in_col, in_row, out_col;
      conv_result_type pending_pixels [$];
      int              errors, results_seen, beats_in;

      function new();
         radius_reg = 1;
         width_reg  = 640;
         height_reg = 480;
         foreach (coef_row[i]) coef_row[i] = '0;
         foreach (line_store[i]) line_store[i] = '0;
         foreach (window[i]) window[i] = '0;
         in_col = 0;
         in_row = 0;
         out_col = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [59:0] value);
         case (idx)
            CSR_RADIUS: radius_reg = value[1:0];
            CSR_WIDTH:  width_reg  = value[11:0];
            CSR_HEIGHT: height_reg = value[12:0];
            CSR_COEF0:  coef_row[0] = value;
            CSR_COEF1:  coef_row[1] = value;
            CSR_COEF2:  coef_row[2] = value;
            CSR_COEF3:  coef_row[3] = value;
            default:    coef_row[4] = value;
         endcase
      endfunction

      function longint weighted_sum(int j, int c, int r, int w);
         longint acc;
         int col, d;
         coef_type cf;
         acc = 0;
         for (int k = 0; k <= 2*r; k++) begin
            for (int l = 0; l <= 2*r; l++) begin
               col = j + l - r;
               if (col > w - 1) col = w - 1;
               d = c - col;
               if (d < 0) d = 0;
               if (d > 4) d = 4;
               cf = coef_row[k][12*l +: 12];
               acc += longint'(cf) * longint'(window[(4 - d)*5 + k]);
            end
         end
         return acc;
      endfunction

      // divide by 1024, round half to even, clamp to the pixel range
      function logic [7:0] to_pixel(longint acc);
         longint q, rem;
         if (acc <= 0) return 8'd0;
         q = acc >>> 10;
         rem = acc & 1023;
         if (rem > 512 || (rem == 512 && q[0])) q++;
         return (q > 255) ? 8'd255 : q[7:0];
      endfunction

      function void note_input(logic kind, logic [7:0] pix);
         int r, w, h, row, c, q, end_col, n;
         bit flush_row, last_col, final_row, re;
         logic [7:0] vec [5];
         conv_result_type res;
         r = radius_reg;
         w = width_reg;
         h = height_reg;
         if (r < 1) r = 1;
         if (r > 2) r = 2;
         if (w < 1) w = 1;
         if (w > 2048) w = 2048;
         if (h < 1) h = 1;
         if (h > MAX_HEIGHT) h = MAX_HEIGHT;
         row = in_row;
         flush_row = row >= h;
         // wrong kind of beat for this row is dropped
         if (kind != flush_row) return;
         beats_in++;
         last_col = in_col >= w - 1;
         c = last_col ? w - 1 : in_col;
         final_row = row >= h + r - 1;
         foreach (vec[k]) vec[k] = '0;
         for (int k = 0; k <= 2*r; k++) begin
            q = row - 2*r + k;
            if (q < 0) q = 0;
            if (q > h - 1) q = h - 1;
            vec[k] = (!flush_row && q == row) ? pix : line_store[(q % 4)*2048 + c];
         end
         if (c == 0) begin
            for (int p = 0; p < 5; p++)
               for (int k = 0; k < 5; k++) window[p*5 + k] = vec[k];
         end else begin
            for (int i = 0; i < 20; i++) window[i] = window[i + 5];
            for (int k = 0; k < 5; k++) window[20 + k] = vec[k];
         end
         if (!flush_row) line_store[(row % 4)*2048 + c] = pix;
         n = 0;
         if (row >= r && (last_col || c >= r)) begin
            end_col = last_col ? w - 1 : c - r;
            while (out_col <= end_col && n < r + 1) begin
               re = (out_col == w - 1);
               res.pixel = to_pixel(weighted_sum(out_col, c, r, w));
               res.row_end = re;
               res.image_end = re && final_row;
               res.last = 1'b0;
               pending_pixels.push_back(res);
               n++;
               out_col++;
            end
            if (n > 0) pending_pixels[pending_pixels.size() - 1].last = 1'b1;
         end
         if (last_col) begin
            in_col = 0;
            out_col = 0;
            in_row = final_row ? 0 : in_row + 1;
         end else begin
            in_col++;
         end
      endfunction

      function void check_result(logic [7:0] pix, logic [1:0] marks, logic last);
         conv_result_type exp_res;
         results_seen++;
         if (pending_pixels.size() == 0) begin
            $error("unexpected result beat: pixel_out %0d", pix);
            errors++;
            return;
         end
         exp_res = pending_pixels.pop_front();
         if (pix !== exp_res.pixel) begin
            $error("pixel_out expected %0d actual %0d", exp_res.pixel, pix);
            errors++;
         end
         if (marks[0] !== exp_res.row_end) begin
            $error("row_end expected %0b actual %0b", exp_res.row_end, marks[0]);
            errors++;
         end
         if (marks[1] !== exp_res.image_end) begin
            $error("image_end expected %0b actual %0b", exp_res.image_end, marks[1]);
            errors++;
         end
         if (last !== exp_res.last) begin
            $error("last_of_run expected %0b actual %0b", exp_res.last, last);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // [7:0] pixel_in
   logic        req_tuser = 1'b0; // [0] req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // [7:0] pixel_out
   logic [1:0]  rsp_tuser;        // [0] row_end, [1] image_end
   logic        rsp_tlast;        // last_of_run
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [59:0] csr_data = '0;

   conv_scoreboard conv_sb = new();

   // idling percentages of the current phase
   int sender_idle_pct = 0;
   int sink_stall_pct = 0;
   int images_run = 0;

   image_conv2d_replicate_border_core dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side: random back-pressure, every accepted beat goes to the scoreboard
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) conv_sb.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
      rsp_tready <= ($urandom_range(99) >= sink_stall_pct);
   end

   // generous hard limit; slowest legal run is well under this
   initial begin
      #20ms;
      $display("image_conv2d_replicate_border_core verification failed");
      $finish;
   end

   task automatic csr_write(csr_index_type idx, logic [59:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      conv_sb.write_reg(idx, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // one pixel or flush beat, with random idle cycles ahead of it
   task automatic send_beat(logic kind, logic [7:0] pix);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= pix;
      do @(posedge clock); while (!req_tready);
      conv_sb.note_input(kind, pix);
   endtask

   // wait for the pipeline to drain, then idle before returning
   task automatic drain();
      req_tvalid <= 1'b0;
      while (conv_sb.pending_pixels.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // five coefficients of magnitude up to mag, or fully random bits when mag is 0
   function automatic logic [59:0] coef_pack(int mag);
      logic [59:0] v;
      int cf;
      for (int l = 0; l < 5; l++) begin
         cf = (mag == 0) ? int'($urandom_range(4095)) : int'($urandom_range(2*mag)) - mag;
         v[12*l +: 12] = cf[11:0];
      end
      return v;
   endfunction

   // one image with its flush rows; pix_mode 0 random, 1 black and white, 2 odd values;
   // noisy images also carry beats of the wrong kind
   task automatic run_image(int r_reg, int w_reg, int h_reg, logic [59:0] rows [5],
                            int pix_mode, bit noisy);
      int r, w, h;
      logic [7:0] pix;
      drain();
      sender_idle_pct = (images_run % 4 == 1 || images_run % 4 == 3) ?
                        ((images_run % 4 == 3) ? 33 : 45) : 0;
      sink_stall_pct  = (images_run % 4 == 2) ? 45 : ((images_run % 4 == 3) ? 33 : 0);
      csr_write(CSR_RADIUS, 60'(r_reg));
      csr_write(CSR_WIDTH,  60'(w_reg));
      csr_write(CSR_HEIGHT, 60'(h_reg));
      csr_write(CSR_COEF0, rows[0]);
      csr_write(CSR_COEF1, rows[1]);
      csr_write(CSR_COEF2, rows[2]);
      csr_write(CSR_COEF3, rows[3]);
      csr_write(CSR_COEF4, rows[4]);
      r = (r_reg < 1) ? 1 : ((r_reg > 2) ? 2 : r_reg);
      w = (w_reg < 1) ? 1 : ((w_reg > 2048) ? 2048 : w_reg);
      h = (h_reg < 1) ? 1 : ((h_reg > MAX_HEIGHT) ? MAX_HEIGHT : h_reg);
      for (int i = 0; i < w*h; i++) begin
         if (noisy && $urandom_range(19) == 0) send_beat(1'b1, 8'($urandom));
         case (pix_mode)
            1:       pix = (i % 2) ? 8'hFF : 8'h00;
            2:       pix = 8'($urandom) | 8'h01;
            default: pix = 8'($urandom);
         endcase
         send_beat(1'b0, pix);
      end
      for (int i = 0; i < w*r; i++) begin
         if (noisy && $urandom_range(19) == 0) send_beat(1'b0, 8'($urandom));
         send_beat(1'b1, 8'($urandom));
      end
      images_run++;
   endtask

   initial begin
      logic [59:0] rows [5];
      logic [59:0] ident;
      logic [59:0] half;
      ident = '0;
      ident[12*2 +: 12] = 12'd1024;
      half = '0;
      half[12*2 +: 12] = 12'd512;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // unit tap at kernel row 1, column 2, black and white pixels, stray beats of the wrong kind
      rows = '{60'd0, ident, 60'd0, 60'd0, 60'd0};
      run_image(1, 3, 2, rows, 1, 1'b1);
      // half-weight centre on odd pixels: exact ties for round half to even
      half[12*2 +: 12] = 12'd512;
      rows = '{60'd0, 60'd0, half, 60'd0, 60'd0};
      run_image(2, 4, 3, rows, 2, 1'b0);
      // zero radius, width and height act as one; largest positive coefficients
      rows = '{60'hFFF_FFFF_FFFF_FFFF & {5{12'h7FF}}, {5{12'h7FF}}, {5{12'h7FF}},
               {5{12'h7FF}}, {5{12'h7FF}}};
      run_image(0, 0, 0, rows, 0, 1'b1);
      // radius above the maximum, most negative coefficients
      rows = '{{5{12'h800}}, {5{12'h800}}, {5{12'h800}}, {5{12'h800}}, {5{12'h800}}};
      run_image(3, 2, 2, rows, 0, 1'b0);

      // random images: small sizes, random kernels and pixels
      while (conv_sb.beats_in < 320) begin
         foreach (rows[i]) rows[i] = ($urandom_range(3) == 0) ? coef_pack(0) : coef_pack(300);
         rows[$urandom_range(4)][12*$urandom_range(4) +: 12] = 12'd1024;
         run_image($urandom_range(1, 2), $urandom_range(1, 12), $urandom_range(1, 6), rows, 0,
                   $urandom_range(4) == 0);
      end

      drain();
      $display("ran %0d images, %0d accepted input beats, %0d result beats checked",
               images_run, conv_sb.beats_in, conv_sb.results_seen);
      $display("small images at both radii, out-of-range settings, idling and stalls on both sides");
      if (conv_sb.errors == 0 && conv_sb.pending_pixels.size() == 0) begin
         $display("image_conv2d_replicate_border_core verification clean");
      end else begin
         $display("image_conv2d_replicate_border_core verification failed");
      end
      $finish;
   end

endmodule
